FILE: rtl/segment_overlap_grid_counter_assert.svh
// assertion macros for the segment overlap grid counter
`ifndef SEGMENT_OVERLAP_GRID_COUNTER_ASSERT_SVH
`define SEGMENT_OVERLAP_GRID_COUNTER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SOGC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SOGC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/sogc_pkg.sv
package sogc_pkg;

  localparam int COORD_W   = 10;
  localparam int GRID_DIM  = 1024;
  localparam int GRID_AW   = $clog2(GRID_DIM);
  localparam int CELLS     = GRID_DIM * GRID_DIM;
  localparam int CELL_AW   = $clog2(CELLS);
  localparam int HIT_W     = 2;
  localparam int HIT_LIMIT = 2;
  localparam int TOTAL_W   = 21;
  localparam int Q_DEPTH   = 2;
  localparam int Q_AW      = $clog2(Q_DEPTH);
  localparam int CMP_W     = ((COORD_W > GRID_AW) ? COORD_W : GRID_AW) + 1;
  localparam int MUL_W     = COORD_W + CELL_AW;

  // one classified segment, as handed from front to back
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] n;
    logic               x_inc;
    logic               x_dec;
    logic               y_inc;
    logic               y_dec;
    logic               skip;
  } seg_desc_t;

  // back end status seen by the front end
  typedef struct packed {
    logic pop;
    logic clearing;
  } bk_status_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_WALK
  } bk_state_t;

  function automatic logic in_grid(input logic [COORD_W-1:0] x,
                                   input logic [COORD_W-1:0] y);
    return (CMP_W'(x) < CMP_W'(GRID_DIM)) && (CMP_W'(y) < CMP_W'(GRID_DIM));
  endfunction

  // row-major cell address, valid only for cells inside the grid
  function automatic logic [CELL_AW-1:0] cell_addr(input logic [COORD_W-1:0] x,
                                                   input logic [COORD_W-1:0] y);
    logic [MUL_W-1:0] wide;
    wide = MUL_W'(y) * MUL_W'(GRID_DIM) + MUL_W'(x);
    return wide[CELL_AW-1:0];
  endfunction

endpackage

FILE: rtl/segment_overlap_grid_counter.sv
// channel  | signals                               | direction | request
// ---------+---------------------------------------+-----------+----------------------------
// seg      | seg_valid, seg_stall, start_x/y, end_x/y | in     | one segment, two end points
// res      | res_valid, res_stall, overlap_cells, skipped | out | running overlap count, skip
//
// a segment of n+1 cells goes through the back end as a start step, one grid
// read-modify-write per cell and a write-settle step; a skipped segment walks one
// cell and leaves the grid untouched
// after reset the grid is cleared one cell a cycle, all GRID_DIM*GRID_DIM cells,
// while the two-entry queue still takes requests
// a stalled result holds the back end before its next segment; the queue then fills
`include "segment_overlap_grid_counter_assert.svh"

module segment_overlap_grid_counter (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         seg_valid,
  output logic                         seg_stall,
  input  logic [sogc_pkg::COORD_W-1:0] start_x,
  input  logic [sogc_pkg::COORD_W-1:0] start_y,
  input  logic [sogc_pkg::COORD_W-1:0] end_x,
  input  logic [sogc_pkg::COORD_W-1:0] end_y,
  output logic                         res_valid,
  input  logic                         res_stall,
  output logic [sogc_pkg::TOTAL_W-1:0] overlap_cells,
  output logic                         skipped
);

  // classified segments waiting for the rasterizer
  logic                 q_valid;
  sogc_pkg::seg_desc_t  q_desc;
  sogc_pkg::bk_status_t bk_stat;

  // front: direction, span and skip decision, then a short queue
  sogc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .seg_valid (seg_valid),
    .seg_stall (seg_stall),
    .start_x   (start_x),
    .start_y   (start_y),
    .end_x     (end_x),
    .end_y     (end_y),
    .bk_stat   (bk_stat),
    .q_valid   (q_valid),
    .q_desc    (q_desc)
  );

  // back: clear sweep, cell walker, saturating hit counters, overlap total
  sogc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_desc        (q_desc),
    .bk_stat       (bk_stat),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .overlap_cells (overlap_cells),
    .skipped       (skipped)
  );

  // the back end only takes a queued segment that exists
  `SOGC_ASSERT_NOW(a_pop_has_entry, bk_stat.pop, q_valid, "pop from empty segment queue")
  // nothing leaves the queue and no result appears during the clear sweep
  `SOGC_ASSERT_NOW(a_no_pop_clear, bk_stat.clearing, !bk_stat.pop, "segment taken while clearing")
  `SOGC_ASSERT_NOW(a_no_res_clear, bk_stat.clearing, !res_valid, "result while clearing")
  // every pop enters the walk state, so pops never come back to back
  `SOGC_ASSERT_NEXT(a_pop_spaced, bk_stat.pop, !bk_stat.pop, "back-to-back segment pops")

endmodule

FILE: rtl/sogc_ram.sv
module sogc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/sogc_front.sv
module sogc_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        seg_valid,
  output logic                        seg_stall,
  input  logic [sogc_pkg::COORD_W-1:0] start_x,
  input  logic [sogc_pkg::COORD_W-1:0] start_y,
  input  logic [sogc_pkg::COORD_W-1:0] end_x,
  input  logic [sogc_pkg::COORD_W-1:0] end_y,
  input  sogc_pkg::bk_status_t        bk_stat,
  output logic                        q_valid,
  output sogc_pkg::seg_desc_t         q_desc
);

  logic signed [sogc_pkg::COORD_W:0] dx;
  logic signed [sogc_pkg::COORD_W:0] dy;
  logic signed [sogc_pkg::COORD_W:0] dx_abs;
  logic signed [sogc_pkg::COORD_W:0] dy_abs;
  logic [sogc_pkg::COORD_W-1:0]      adx;
  logic [sogc_pkg::COORD_W-1:0]      ady;
  sogc_pkg::seg_desc_t               desc;

  sogc_pkg::seg_desc_t               q_mem [sogc_pkg::Q_DEPTH];
  logic [sogc_pkg::Q_AW-1:0]         wr_ptr;
  logic [sogc_pkg::Q_AW-1:0]         rd_ptr;
  logic [sogc_pkg::Q_AW:0]           q_count;
  logic                              push;

  // classify the segment
  always_comb begin
    dx     = $signed({1'b0, end_x}) - $signed({1'b0, start_x});
    dy     = $signed({1'b0, end_y}) - $signed({1'b0, start_y});
    dx_abs = dx[sogc_pkg::COORD_W] ? -dx : dx;
    dy_abs = dy[sogc_pkg::COORD_W] ? -dy : dy;
    adx    = dx_abs[sogc_pkg::COORD_W-1:0];
    ady    = dy_abs[sogc_pkg::COORD_W-1:0];

    desc.x     = start_x;
    desc.y     = start_y;
    desc.n     = (adx > ady) ? adx : ady;
    desc.x_dec = dx[sogc_pkg::COORD_W];
    desc.x_inc = !dx[sogc_pkg::COORD_W] && (dx != '0);
    desc.y_dec = dy[sogc_pkg::COORD_W];
    desc.y_inc = !dy[sogc_pkg::COORD_W] && (dy != '0);
    desc.skip  = !((dx == '0) || (dy == '0) || (adx == ady));
  end

  // short request queue toward the back end
  assign seg_stall = (q_count == (sogc_pkg::Q_AW + 1)'(sogc_pkg::Q_DEPTH));
  assign push      = seg_valid && !seg_stall;
  assign q_valid   = (q_count != '0);
  assign q_desc    = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == sogc_pkg::Q_AW'(sogc_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (bk_stat.pop) begin
        rd_ptr <= (rd_ptr == sogc_pkg::Q_AW'(sogc_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !bk_stat.pop) begin
        q_count <= q_count + 1'b1;
      end else if (!push && bk_stat.pop) begin
        q_count <= q_count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= desc;
    end
  end

endmodule

FILE: rtl/sogc_back.sv
module sogc_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  sogc_pkg::seg_desc_t          q_desc,
  output sogc_pkg::bk_status_t         bk_stat,
  output logic                         res_valid,
  input  logic                         res_stall,
  output logic [sogc_pkg::TOTAL_W-1:0] overlap_cells,
  output logic                         skipped
);

  sogc_pkg::bk_state_t               state;
  sogc_pkg::bk_state_t               state_next;

  logic [sogc_pkg::COORD_W-1:0]      cur_x;
  logic [sogc_pkg::COORD_W-1:0]      cur_y;
  logic [sogc_pkg::COORD_W-1:0]      remain;
  logic                              x_inc;
  logic                              x_dec;
  logic                              y_inc;
  logic                              y_dec;
  logic                              cur_skip;
  logic [sogc_pkg::CELL_AW-1:0]      clr_addr;

  logic                              s1_valid;
  logic [sogc_pkg::CELL_AW-1:0]      s1_addr;
  logic                              s1_inb;
  logic                              s1_last;
  logic                              s1_skip;

  logic [sogc_pkg::TOTAL_W-1:0]      total;
  logic [sogc_pkg::TOTAL_W-1:0]      total_next;

  logic                              pop;
  logic                              step;
  logic                              last;
  logic                              step_inb;
  logic                              out_free;
  logic [sogc_pkg::CELL_AW-1:0]      rd_addr;
  logic [sogc_pkg::HIT_W-1:0]        rd_data;
  logic [sogc_pkg::HIT_W-1:0]        hit_inc;
  logic                              hit_sat;
  logic                              count_up;
  logic                              ram_we;
  logic [sogc_pkg::CELL_AW-1:0]      ram_waddr;
  logic [sogc_pkg::HIT_W-1:0]        ram_wdata;

  assign last     = (remain == '0);
  assign step_inb = !cur_skip && sogc_pkg::in_grid(cur_x, cur_y);
  assign rd_addr  = sogc_pkg::cell_addr(cur_x, cur_y);
  assign out_free = !res_valid || !res_stall;

  // sequencer: clear sweep, then one cell per cycle along each segment
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    step       = 1'b0;
    unique case (state)
      sogc_pkg::BK_CLEAR: begin
        if (clr_addr == sogc_pkg::CELL_AW'(sogc_pkg::CELLS - 1)) begin
          state_next = sogc_pkg::BK_IDLE;
        end
      end
      sogc_pkg::BK_IDLE: begin
        // wait for the previous write to land so the next read sees it
        if (q_valid && !s1_valid && out_free) begin
          pop        = 1'b1;
          state_next = sogc_pkg::BK_WALK;
        end
      end
      sogc_pkg::BK_WALK: begin
        step = 1'b1;
        if (last) begin
          state_next = sogc_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = sogc_pkg::BK_IDLE;
      end
    endcase
  end

  assign bk_stat.pop      = pop;
  assign bk_stat.clearing = (state == sogc_pkg::BK_CLEAR);

  // read-modify-write of the cell counter
  assign hit_sat  = (rd_data >= sogc_pkg::HIT_W'(sogc_pkg::HIT_LIMIT));
  assign hit_inc  = rd_data + 1'b1;
  assign count_up = s1_valid && s1_inb && !hit_sat &&
                    (hit_inc == sogc_pkg::HIT_W'(sogc_pkg::HIT_LIMIT));

  always_comb begin
    total_next = total;
    if (count_up && (total != '1)) begin
      total_next = total + 1'b1;
    end
  end

  always_comb begin
    if (state == sogc_pkg::BK_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = s1_valid && s1_inb && !hit_sat;
      ram_waddr = s1_addr;
      ram_wdata = hit_inc;
    end
  end

  sogc_ram #(
    .WIDTH (sogc_pkg::HIT_W),
    .DEPTH (sogc_pkg::CELLS)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (step && step_inb),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sogc_pkg::BK_CLEAR;
      clr_addr  <= '0;
      s1_valid  <= 1'b0;
      total     <= '0;
      res_valid <= 1'b0;
    end else begin
      state    <= state_next;
      s1_valid <= step;
      total    <= total_next;
      if (state == sogc_pkg::BK_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (s1_valid && s1_last) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_x    <= q_desc.x;
      cur_y    <= q_desc.y;
      remain   <= q_desc.skip ? '0 : q_desc.n;
      x_inc    <= q_desc.x_inc;
      x_dec    <= q_desc.x_dec;
      y_inc    <= q_desc.y_inc;
      y_dec    <= q_desc.y_dec;
      cur_skip <= q_desc.skip;
    end else if (step) begin
      if (x_inc) begin
        cur_x <= cur_x + 1'b1;
      end else if (x_dec) begin
        cur_x <= cur_x - 1'b1;
      end
      if (y_inc) begin
        cur_y <= cur_y + 1'b1;
      end else if (y_dec) begin
        cur_y <= cur_y - 1'b1;
      end
      remain <= remain - 1'b1;
    end
    if (step) begin
      s1_addr <= rd_addr;
      s1_inb  <= step_inb;
      s1_last <= last;
      s1_skip <= cur_skip;
    end
    if (s1_valid && s1_last) begin
      overlap_cells <= total_next;
      skipped       <= s1_skip;
    end
  end

endmodule
